// ----- sv/pnc_pkg.sv -----
`default_nettype none

package pnc_pkg;

  localparam int unsigned MAX_COLORS_DEF = 16;
  localparam int unsigned NumColorsW     = 5;
  localparam logic [NumColorsW-1:0] NumColorsRst = 5'd16;
  localparam int unsigned EntryIdxW      = 4;
  localparam int unsigned CompW          = 8;
  localparam int unsigned SqW            = 2 * CompW;
  localparam int unsigned DistW          = SqW + 2;

  localparam logic ActWrite = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
  } pnc_rgb_t;

  typedef struct packed {
    pnc_rgb_t rgb;
    logic     include_gray;
  } pnc_query_t;

  function automatic logic [SqW-1:0] sq_diff(logic [CompW-1:0] a, logic [CompW-1:0] b);
    logic [CompW-1:0] d;
    logic [SqW-1:0]   dw;
    d  = (a > b) ? (a - b) : (b - a);
    dw = {{CompW{1'b0}}, d};
    return dw * dw;
  endfunction

endpackage

`default_nettype wire

// ----- sv/pnc_in_if.sv -----
`default_nettype none

interface pnc_in_if;
  import pnc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [EntryIdxW-1:0] entry_index;
  logic [CompW-1:0]     red;
  logic [CompW-1:0]     green;
  logic [CompW-1:0]     blue;
  logic                 include_gray;

  modport source (
    output valid, action, entry_index, red, green, blue, include_gray,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, red, green, blue, include_gray,
    output ready
  );

endinterface

`default_nettype wire

// ----- sv/pnc_out_if.sv -----
`default_nettype none

interface pnc_out_if;
  import pnc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [EntryIdxW-1:0] best_index;
  logic [CompW-1:0]     best_red;
  logic [CompW-1:0]     best_green;
  logic [CompW-1:0]     best_blue;

  modport source (
    output valid, found, best_index, best_red, best_green, best_blue,
    input  ready
  );

  modport sink (
    input  valid, found, best_index, best_red, best_green, best_blue,
    output ready
  );

endinterface

`default_nettype wire

// ----- sv/palette_nearest_color_search.sv -----
// Nearest palette color search over a palette of MaxColors RGB entries.
// The input channel in_i carries two kinds of beats. A write beat (action 0)
// stores red, green and blue at entry_index and produces no result; an index
// at or beyond MaxColors is dropped. A query beat (action 1) scans entries
// 0 to min(num_colors, MaxColors)-1 and returns one result beat on out_o with
// the first entry of smallest squared distance, skipping gray entries unless
// include_gray is set. With no qualifying entry, found and all fields are 0.
// The palette sits in one synchronous RAM read one entry per cycle. A query
// occupies the block while it scans its entries, drains the pipeline and
// loads the result register; an empty scan goes straight to the last step.
// A write beat leaves the block idle. in_i.ready is high only while no query
// is in progress. The result waits in an output register: a stalled receiver
// does not stop the next beat from being accepted, but the following query
// holds in its final step until the register is free. num_colors is written
// through cfg_we_i and cfg_wdata_i; the user must write it only while the
// block is idle, which the block itself does not enforce. Reset sets
// num_colors to 16 and makes every palette entry read as zero; no clearing pass.
`default_nettype none

module palette_nearest_color_search import pnc_pkg::*; #(
  parameter int unsigned MaxColors = MAX_COLORS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [NumColorsW-1:0] cfg_wdata_i,
  pnc_in_if.sink                     in_i,
  pnc_out_if.source                  out_o
);

  localparam int unsigned IdxW = $clog2(MaxColors);
  localparam int unsigned LimW = $clog2(MaxColors + 1);
  localparam int unsigned CntW = (LimW > NumColorsW) ? LimW : NumColorsW;

  logic [NumColorsW-1:0] num_colors_q;
  logic                  idle;
  logic                  accept;
  logic                  start;
  logic                  mem_we;
  logic [IdxW+EntryIdxW-1:0] waddr_ext;
  logic [IdxW-1:0]       waddr;
  pnc_rgb_t              in_rgb;
  pnc_query_t            query;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;
  pnc_rgb_t              rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_colors_q <= NumColorsRst;
    end else if (cfg_we_i) begin
      num_colors_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = idle;
  assign accept     = in_i.valid && idle;
  assign start      = accept && (in_i.action == ActQuery);
  assign in_rgb     = '{red: in_i.red, green: in_i.green, blue: in_i.blue};
  assign query      = '{rgb: in_rgb, include_gray: in_i.include_gray};

  assign waddr_ext = {{IdxW{1'b0}}, in_i.entry_index};
  assign waddr     = waddr_ext[IdxW-1:0];
  assign mem_we    = accept && (in_i.action == ActWrite)
                  && (CntW'(in_i.entry_index) < CntW'(MaxColors));

  pnc_palette_mem #(
    .MaxColors(MaxColors)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(waddr),
    .wdata_i(in_rgb),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  pnc_scan #(
    .MaxColors(MaxColors)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .num_colors_i(num_colors_q),
    .start_i     (start),
    .query_i     (query),
    .idle_o      (idle),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ----- sv/pnc_palette_mem.sv -----
`default_nettype none

module pnc_palette_mem import pnc_pkg::*; #(
  parameter int unsigned MaxColors = MAX_COLORS_DEF,
  localparam int unsigned IdxW = $clog2(MaxColors)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  pnc_rgb_t             wdata_i,
  input  wire logic            re_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output pnc_rgb_t             rdata_o
);

  pnc_rgb_t             mem_q [MaxColors];
  pnc_rgb_t             rdata_q;
  logic                 rvalid_q;
  logic [MaxColors-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Entries never written read as zero, which is the reset content.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ----- sv/pnc_scan.sv -----
`default_nettype none

module pnc_scan import pnc_pkg::*; #(
  parameter int unsigned MaxColors = MAX_COLORS_DEF,
  localparam int unsigned IdxW = $clog2(MaxColors)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [NumColorsW-1:0] num_colors_i,
  input  wire logic                  start_i,
  input  pnc_query_t                 query_i,
  output logic                       idle_o,
  output logic                       rd_en_o,
  output logic [IdxW-1:0]            rd_addr_o,
  input  pnc_rgb_t                   rd_data_i,
  pnc_out_if.source                  out_o
);

  localparam int unsigned LimW = $clog2(MaxColors + 1);
  localparam int unsigned CntW = (LimW > NumColorsW) ? LimW : NumColorsW;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] limit_q, limit_d;
  logic [CntW-1:0] nc_ext;
  pnc_query_t      qry_q;

  logic            s1_vld_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            s2_vld_q;
  logic            s2_ok_q;
  logic [IdxW-1:0] s2_idx_q;
  pnc_rgb_t        s2_rgb_q;
  logic [DistW-1:0] s2_dist_q;

  logic            s1_gray;
  logic            s1_ok;
  logic [DistW-1:0] s1_dist;
  logic            take;

  logic            found_q;
  logic [IdxW-1:0] best_idx_q;
  pnc_rgb_t        best_rgb_q;
  logic [DistW-1:0] best_dist_q;

  logic            out_load;
  logic            out_vld_q;
  logic            out_found_q;
  logic [EntryIdxW-1:0] out_idx_q;
  pnc_rgb_t        out_rgb_q;
  logic [IdxW+EntryIdxW-1:0] best_idx_ext;

  assign nc_ext  = CntW'(num_colors_i);
  assign limit_d = (nc_ext > CntW'(MaxColors)) ? CntW'(MaxColors) : nc_ext;

  assign idle_o    = (state_q == StIdle);
  assign rd_en_o   = (state_q == StScan);
  assign rd_addr_o = cnt_q[IdxW-1:0];
  assign out_load  = (state_q == StDone) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cnt_d   = '0;
          state_d = (limit_d == '0) ? StDone : StScan;
        end
      end
      StScan: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == limit_q - 1'b1) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign s1_gray = (rd_data_i.red == rd_data_i.green) && (rd_data_i.red == rd_data_i.blue);
  assign s1_ok   = qry_q.include_gray || !s1_gray;
  assign s1_dist = DistW'(sq_diff(rd_data_i.red, qry_q.rgb.red))
                 + DistW'(sq_diff(rd_data_i.green, qry_q.rgb.green))
                 + DistW'(sq_diff(rd_data_i.blue, qry_q.rgb.blue));

  assign take = s2_vld_q && s2_ok_q && (!found_q || (s2_dist_q < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      limit_q   <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      s1_vld_q <= rd_en_o;
      s2_vld_q <= s1_vld_q;
      if (start_i) begin
        limit_q <= limit_d;
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qry_q <= query_i;
    end
    s1_idx_q  <= rd_addr_o;
    s2_idx_q  <= s1_idx_q;
    s2_ok_q   <= s1_ok;
    s2_rgb_q  <= rd_data_i;
    s2_dist_q <= s1_dist;
    if (take) begin
      best_idx_q  <= s2_idx_q;
      best_rgb_q  <= s2_rgb_q;
      best_dist_q <= s2_dist_q;
    end
  end

  assign best_idx_ext = {{EntryIdxW{1'b0}}, best_idx_q};

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= found_q;
      out_idx_q   <= found_q ? best_idx_ext[EntryIdxW-1:0] : '0;
      out_rgb_q   <= found_q ? best_rgb_q : '0;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.found      = out_found_q;
  assign out_o.best_index = out_idx_q;
  assign out_o.best_red   = out_rgb_q.red;
  assign out_o.best_green = out_rgb_q.green;
  assign out_o.best_blue  = out_rgb_q.blue;

endmodule

`default_nettype wire

// ----- sv/pnc_checker.sv -----
`default_nettype none

module pnc_checker import pnc_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_i,
  input wire logic                 in_action_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic                 out_found_i,
  input wire logic [EntryIdxW-1:0] out_best_index_i,
  input wire logic [CompW-1:0]     out_best_red_i,
  input wire logic [CompW-1:0]     out_best_green_i,
  input wire logic [CompW-1:0]     out_best_blue_i
);

  // A pending result beat holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i
      && $stable(out_found_i) && $stable(out_best_index_i)
      && $stable(out_best_red_i) && $stable(out_best_green_i)
      && $stable(out_best_blue_i))
    else $error("result beat changed while stalled");

  // A miss reports index and color as zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_best_index_i == '0
      && out_best_red_i == '0 && out_best_green_i == '0 && out_best_blue_i == '0)
    else $error("miss result carries nonzero fields");

  // A query occupies the block, so the next cycle takes no beat.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i == ActQuery |=> !in_ready_i)
    else $error("input accepted during a query");

  // A palette write leaves the block ready for the next beat.
  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i == ActWrite |=> in_ready_i)
    else $error("block busy after a palette write");

endmodule

bind palette_nearest_color_search pnc_checker u_pnc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_action_i     (in_i.action),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_found_i     (out_o.found),
  .out_best_index_i(out_o.best_index),
  .out_best_red_i  (out_o.best_red),
  .out_best_green_i(out_o.best_green),
  .out_best_blue_i (out_o.best_blue)
);

`default_nettype wire
